// ===== rtl/agb_pkg.sv =====
// Shared types, constants and helpers of the grid cell binning block.
`default_nettype none

package agb_pkg;

    localparam int MAX_RUN        = 64;
    localparam int AXIS_COUNT_MAX = 64;

    localparam int COORD_W    = 32;
    localparam int SIZE_W     = 31;
    localparam int COUNTS_W   = 21;
    localparam int TAG_W      = 16;
    localparam int IDX_W      = 18;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 7;
    localparam int POS_W      = 6;
    localparam int DIV_W      = 33;
    localparam int DIV_STEPS  = 7;
    localparam int STEP_W     = 3;
    localparam int AXES       = 3;

    localparam logic [COORD_W-1:0]  ORIGIN_XY_RST = 32'hFFEC_7800;
    localparam logic [COORD_W-1:0]  ORIGIN_Z_RST  = 32'hFFFF_FF80;
    localparam logic [SIZE_W-1:0]   SIZE_XY_RST   = 31'd256000;
    localparam logic [SIZE_W-1:0]   SIZE_Z_RST    = 31'd256;
    localparam logic [COUNTS_W-1:0] COUNTS_RST    = 21'd17674;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_SIZE_X   = 3'd3,
        REG_SIZE_Y   = 3'd4,
        REG_SIZE_Z   = 3'd5,
        REG_COUNTS   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] origin;
        logic [AXES-1:0][SIZE_W-1:0]  size;
        logic [COUNTS_W-1:0]          counts;
    } t_cfg;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] box_min;
        logic [AXES-1:0][COORD_W-1:0] box_max;
        logic [TAG_W-1:0]             box_tag;
    } t_box;

    typedef struct packed {
        logic [TAG_W-1:0] result_tag;
        logic [IDX_W-1:0] cell_index;
        logic             last_cell;
        logic             run_truncated;
    } t_cell;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPAN,
        ST_MUL1,
        ST_MUL2,
        ST_START,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              load;
        logic              div_step;
        logic [STEP_W-1:0] step_k;
        logic              span;
        logic              mul1;
        logic              mul2;
        logic              start;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last;
        logic can_emit;
    } t_status;

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        if (c > CNT_W'(AXIS_COUNT_MAX)) begin
            return CNT_W'(AXIS_COUNT_MAX);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/agb_box_if.sv =====
// Input channel: one box word with valid and ready.
`default_nettype none

interface agb_box_if;
    import agb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic [TAG_W-1:0]          box_tag;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z, box_tag,
        input  ready
    );

    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z,
               box_max_x, box_max_y, box_max_z, box_tag,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/agb_cell_if.sv =====
// Output channel: one cell word with valid and ready.
`default_nettype none

interface agb_cell_if;
    import agb_pkg::*;

    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] result_tag;
    logic [IDX_W-1:0] cell_index;
    logic             last_cell;
    logic             run_truncated;

    modport source (
        output valid, result_tag, cell_index, last_cell, run_truncated,
        input  ready
    );

    modport sink (
        input  valid, result_tag, cell_index, last_cell, run_truncated,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/aabb_grid_cell_binning.sv =====
// Uniform grid cell binning of axis-aligned boxes: top level.
//
// Boxes arrive on i_box (valid/ready); one word per covered grid cell leaves on
// o_cell, z outermost and x innermost, with the box tag, linear cell index, a
// last-cell flag and a truncation flag set on every word of a clipped run.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while the block is idle, which the block itself does
// not enforce. Writes to unmapped indexes are dropped.
//
// A box is accepted while idle, then six divide lanes run seven restoring steps
// in parallel (one quotient bit per cycle, saturating at the axis limit),
// followed by a clamp step (SPAN) and the product steps MUL1 and MUL2. A box
// that covers no cell is finished after MUL1. Otherwise a start step follows
// and the index walker issues one cell per cycle while o_cell is not stalled.
//
// Reset restores the register defaults (10 x 10 x 1 grid) and empties the
// output register. A stalled receiver holds the output word and the walk; the
// next box is taken as soon as the last word of the run sits in the register.
`default_nettype none

module aabb_grid_cell_binning (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    agb_box_if.sink                        i_box,
    agb_cell_if.source                     o_cell,
    input  logic                           i_cfg_we,
    input  logic [agb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [agb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import agb_pkg::*;

    t_cfg    cfg;
    t_box    box;
    t_cmd    cmd;
    t_status status;
    t_cell   cell_word;
    logic    in_ready;
    logic    out_valid;

    assign box.box_min[0] = i_box.box_min_x;
    assign box.box_min[1] = i_box.box_min_y;
    assign box.box_min[2] = i_box.box_min_z;
    assign box.box_max[0] = i_box.box_max_x;
    assign box.box_max[1] = i_box.box_max_y;
    assign box.box_max[2] = i_box.box_max_z;
    assign box.box_tag    = i_box.box_tag;

    agb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    agb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_box.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    agb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_box       (box),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (out_valid),
        .i_out_ready (o_cell.ready),
        .o_out       (cell_word)
    );

    assign i_box.ready          = in_ready;
    assign o_cell.valid         = out_valid;
    assign o_cell.result_tag    = cell_word.result_tag;
    assign o_cell.cell_index    = cell_word.cell_index;
    assign o_cell.last_cell     = cell_word.last_cell;
    assign o_cell.run_truncated = cell_word.run_truncated;

endmodule

`default_nettype wire

// ===== rtl/agb_cfg_regs.sv =====
// Configuration register file: grid origin, cell sizes and cell counts.
`default_nettype none

module agb_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [agb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [agb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output agb_pkg::t_cfg                   o_cfg
);
    import agb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin[0] <= ORIGIN_XY_RST;
            r_cfg.origin[1] <= ORIGIN_XY_RST;
            r_cfg.origin[2] <= ORIGIN_Z_RST;
            r_cfg.size[0]   <= SIZE_XY_RST;
            r_cfg.size[1]   <= SIZE_XY_RST;
            r_cfg.size[2]   <= SIZE_Z_RST;
            r_cfg.counts    <= COUNTS_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ORIGIN_X: r_cfg.origin[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_cfg.origin[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_cfg.origin[2] <= i_cfg_data;
                REG_SIZE_X:   r_cfg.size[0]   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:   r_cfg.size[1]   <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:   r_cfg.size[2]   <= i_cfg_data[SIZE_W-1:0];
                REG_COUNTS:   r_cfg.counts    <= i_cfg_data[COUNTS_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/agb_ctrl.sv =====
// Sequencer: divide steps, span and product setup, then one cell per word slot.
`default_nettype none

module agb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  agb_pkg::t_status  i_status,
    output agb_pkg::t_cmd     o_cmd
);
    import agb_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.step_k = r_step;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = STEP_W'(DIV_STEPS - 1);
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = ST_SPAN;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            ST_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                // an empty box ends here with no word
                n_state    = i_status.empty ? ST_IDLE : ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_START;
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_emit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.can_emit)
        else $error("cell issued with output slot occupied");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_status.last) |=> (r_state == ST_IDLE))
        else $error("run did not end after last cell");

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_DIV && r_step == STEP_W'(DIV_STEPS - 1)))
        else $error("divide did not start after box accepted");

endmodule

`default_nettype wire

// ===== rtl/agb_datapath.sv =====
// Datapath: six saturating divide lanes, clamp and span, index walk, output register.
`default_nettype none

module agb_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  agb_pkg::t_cfg    i_cfg,
    input  agb_pkg::t_box    i_box,
    input  agb_pkg::t_cmd    i_cmd,
    output agb_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output agb_pkg::t_cell   o_out
);
    import agb_pkg::*;

    localparam int LANES = 2 * AXES;
    localparam int SH_W  = DIV_W + DIV_STEPS - 3;  // room for size << 6

    // divide lanes: 0..2 box minimum, 3..5 box maximum
    logic [DIV_W-1:0] r_rem [LANES];
    logic             r_neg [LANES];
    logic             r_sat [LANES];
    logic [POS_W-1:0] r_q   [LANES];
    logic [TAG_W-1:0] r_tag;

    logic [DIV_W-1:0]  lane_d   [LANES];
    logic [DIV_W-1:0]  lane_mag [LANES];
    logic [SH_W-1:0]   lane_sh  [LANES];
    logic [SH_W-1:0]   lane_df  [LANES];
    logic              lane_ge  [LANES];
    logic [SIZE_W-1:0] axis_s   [AXES];
    logic [COORD_W-1:0] lane_c  [LANES];

    // span results
    logic [POS_W-1:0] r_lo   [AXES];
    logic [POS_W-1:0] r_hi   [AXES];
    logic [CNT_W-1:0] r_span [AXES];
    logic             r_empty;
    logic [CNT_W-1:0] r_cx;
    logic [CNT_W-1:0] r_cy;

    logic [CNT_W-1:0] ax_cnt  [AXES];
    logic [CNT_W-1:0] ax_cm1  [AXES];
    logic [CNT_W-1:0] ax_lo   [AXES];
    logic [CNT_W-1:0] ax_hi   [AXES];
    logic [CNT_W-1:0] ax_hic  [AXES];
    logic             ax_empty[AXES];

    // products
    logic [12:0] r_sxy;
    logic [12:0] r_cxcy;
    logic [12:0] r_ybase;
    logic [18:0] r_total;
    logic [IDX_W-1:0] r_zbase;
    logic [13:0] sxy_p;
    logic [13:0] cxcy_p;
    logic [19:0] total_p;
    logic [18:0] zbase_p;

    // walk state
    logic [POS_W-1:0] r_x, r_y, r_z;
    logic [IDX_W-1:0] r_idx, r_row, r_plane;
    logic [CNT_W-1:0] r_n, r_count;
    logic             r_trunc;
    logic [CNT_W-1:0] n_next;
    logic [IDX_W-1:0] plane_next;
    logic [IDX_W-1:0] plane_row;
    logic [IDX_W-1:0] row_next;

    t_cell r_out;
    logic  r_out_valid;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            axis_s[a] = (i_cfg.size[a] == '0) ? SIZE_W'(1) : i_cfg.size[a];
            lane_c[a]        = i_box.box_min[a];
            lane_c[a + AXES] = i_box.box_max[a];
        end
        for (int m = 0; m < 2; m++) begin
            for (int a = 0; a < AXES; a++) begin
                lane_d[m*AXES + a] = {lane_c[m*AXES + a][COORD_W-1], lane_c[m*AXES + a]}
                                   - {i_cfg.origin[a][COORD_W-1], i_cfg.origin[a]};
                lane_mag[m*AXES + a] = lane_d[m*AXES + a][DIV_W-1]
                                     ? (~lane_d[m*AXES + a] + DIV_W'(1))
                                     : lane_d[m*AXES + a];
                lane_sh[m*AXES + a]  = SH_W'(axis_s[a]) << i_cmd.step_k;
                lane_ge[m*AXES + a]  = SH_W'(r_rem[m*AXES + a]) >= lane_sh[m*AXES + a];
                lane_df[m*AXES + a]  = SH_W'(r_rem[m*AXES + a]) - lane_sh[m*AXES + a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= i_box.box_tag;
            for (int l = 0; l < LANES; l++) begin
                r_rem[l] <= lane_mag[l];
                r_neg[l] <= lane_d[l][DIV_W-1];
                r_sat[l] <= 1'b0;
                r_q[l]   <= '0;
            end
        end else if (i_cmd.div_step) begin
            for (int l = 0; l < LANES; l++) begin
                if (lane_ge[l]) begin
                    r_rem[l] <= lane_df[l][DIV_W-1:0];
                    // top step only flags that the quotient reaches the axis limit
                    if (i_cmd.step_k == STEP_W'(DIV_STEPS - 1)) begin
                        r_sat[l] <= 1'b1;
                    end else begin
                        r_q[l][i_cmd.step_k] <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            ax_cnt[a] = sat_count(i_cfg.counts[a*CNT_W +: CNT_W]);
            ax_cm1[a] = ax_cnt[a] - CNT_W'(1);
            ax_lo[a]  = r_neg[a] ? '0
                      : (r_sat[a] ? CNT_W'(AXIS_COUNT_MAX) : {1'b0, r_q[a]});
            ax_hi[a]  = r_neg[a + AXES] ? '0
                      : (r_sat[a + AXES] ? CNT_W'(AXIS_COUNT_MAX) : {1'b0, r_q[a + AXES]});
            ax_hic[a] = (ax_hi[a] > ax_cm1[a]) ? ax_cm1[a] : ax_hi[a];
            // a negative maximum of a cell or more lies before the grid
            ax_empty[a] = (ax_cnt[a] == '0)
                        || (r_neg[a + AXES] && (r_sat[a + AXES] || r_q[a + AXES] != '0))
                        || (ax_lo[a] > ax_hic[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.span) begin
            for (int a = 0; a < AXES; a++) begin
                r_lo[a]   <= ax_lo[a][POS_W-1:0];
                r_hi[a]   <= ax_hic[a][POS_W-1:0];
                r_span[a] <= ax_hic[a] - ax_lo[a] + CNT_W'(1);
            end
            r_empty <= ax_empty[0] || ax_empty[1] || ax_empty[2];
            r_cx    <= ax_cnt[0];
            r_cy    <= ax_cnt[1];
        end
    end

    assign sxy_p   = 14'(r_span[0]) * 14'(r_span[1]);
    assign cxcy_p  = 14'(r_cx) * 14'(r_cy);
    assign total_p = 20'(r_sxy) * 20'(r_span[2]);
    assign zbase_p = 19'(r_lo[2]) * 19'(r_cxcy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_sxy   <= sxy_p[12:0];
            r_cxcy  <= cxcy_p[12:0];
            r_ybase <= 13'(r_lo[1]) * 13'(r_cx);
        end
        if (i_cmd.mul2) begin
            r_total <= total_p[18:0];
            r_zbase <= zbase_p[IDX_W-1:0];
        end
    end

    assign n_next     = r_n + CNT_W'(1);
    assign plane_next = r_plane + IDX_W'(r_cxcy);
    assign plane_row  = plane_next + IDX_W'(r_ybase);
    assign row_next   = r_row + IDX_W'(r_cx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_trunc <= r_total > 19'(MAX_RUN);
            r_count <= (r_total > 19'(MAX_RUN)) ? CNT_W'(MAX_RUN) : r_total[CNT_W-1:0];
            r_idx   <= r_zbase + IDX_W'(r_ybase) + IDX_W'(r_lo[0]);
            r_row   <= r_zbase + IDX_W'(r_ybase);
            r_plane <= r_zbase;
            r_x     <= r_lo[0];
            r_y     <= r_lo[1];
            r_z     <= r_lo[2];
            r_n     <= '0;
        end else if (i_cmd.emit) begin
            r_n <= n_next;
            if (r_x == r_hi[0]) begin
                r_x <= r_lo[0];
                if (r_y == r_hi[1]) begin
                    // next plane restarts at the lowest covered row
                    r_y     <= r_lo[1];
                    r_z     <= r_z + POS_W'(1);
                    r_plane <= plane_next;
                    r_row   <= plane_row;
                    r_idx   <= plane_row + IDX_W'(r_lo[0]);
                end else begin
                    r_y   <= r_y + POS_W'(1);
                    r_row <= row_next;
                    r_idx <= row_next + IDX_W'(r_lo[0]);
                end
            end else begin
                r_x   <= r_x + POS_W'(1);
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.result_tag    <= r_tag;
            r_out.cell_index    <= r_idx;
            r_out.last_cell     <= (n_next == r_count);
            r_out.run_truncated <= r_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.empty    = r_empty;
    assign o_status.last     = (n_next == r_count);
    assign o_status.can_emit = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    a_run_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_n < r_count))
        else $error("cell issued past end of run");

    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_x <= r_hi[0] && r_y <= r_hi[1] && r_z <= r_hi[2]))
        else $error("cell walk left the clamped box");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output word changed while stalled");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the grid cell binning block: directed and random boxes, every cell checked.
`timescale 1ns / 1ps

module testbench;
    import agb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int     GAP_MAX         = 13;
    localparam int     SETTLE_CYCLES   = 24;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     RANDOM_PHASES   = 6;
    localparam int     BOXES_PER_PHASE = 55;
    localparam longint TIMEOUT_CYCLES  = 2000000;
    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;
    localparam longint XY0             = -1280000;
    localparam longint XY_STEP         = 256000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    agb_box_if  box_ch ();
    agb_cell_if cell_ch ();

    aabb_grid_cell_binning dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (box_ch),
        .o_cell      (cell_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the grid registers
    logic signed [COORD_W-1:0] grid_origin [AXES];
    logic [SIZE_W-1:0]         cell_size [AXES];
    logic [COUNTS_W-1:0]       grid_counts;

    t_cell  cells_due [$];
    t_cell  cell_want;
    int     errors = 0;
    longint cycle_count = 0;
    bit     steady = 1'b0;
    int     hold_off_req = 0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        return steady ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic longint axis_cells(input int axis);
        longint c;
        c = longint'(grid_counts[CNT_W*axis +: CNT_W]);
        return (c > AXIS_COUNT_MAX) ? longint'(AXIS_COUNT_MAX) : c;
    endfunction

    function automatic longint step_of(input int axis);
        return (cell_size[axis] == '0) ? 1 : longint'(cell_size[axis]);
    endfunction

    // quotient truncates toward zero, so anything less than a cell below the origin lands in 0
    function automatic longint cell_of_coord(input logic [COORD_W-1:0] coord, input int axis);
        return (longint'($signed(coord)) - longint'(grid_origin[axis])) / step_of(axis);
    endfunction

    function automatic void bin_box(input t_box b);
        longint lo [AXES];
        longint hi [AXES];
        longint cnt [AXES];
        longint covered, x, y, z;
        bit     clipped;
        t_cell  c;
        for (int a = 0; a < AXES; a++) begin
            cnt[a] = axis_cells(a);
            lo[a]  = cell_of_coord(b.box_min[a], a);
            hi[a]  = cell_of_coord(b.box_max[a], a);
            if (lo[a] < 0) lo[a] = 0;
            if (hi[a] > cnt[a] - 1) hi[a] = cnt[a] - 1;
            if (lo[a] > hi[a]) return;
        end
        covered = (hi[0] - lo[0] + 1) * (hi[1] - lo[1] + 1) * (hi[2] - lo[2] + 1);
        clipped = covered > MAX_RUN;
        if (clipped) covered = MAX_RUN;
        x = lo[0];
        y = lo[1];
        z = lo[2];
        for (longint n = 0; n < covered; n++) begin
            c.result_tag    = b.box_tag;
            c.cell_index    = IDX_W'(z * cnt[0] * cnt[1] + y * cnt[0] + x);
            c.last_cell     = (n == covered - 1);
            c.run_truncated = clipped;
            cells_due = {cells_due, c};
            x++;
            if (x > hi[0]) begin
                x = lo[0];
                y++;
                if (y > hi[1]) begin
                    y = lo[1];
                    z++;
                end
            end
        end
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (want !== seen) begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, seen);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && cell_ch.valid && cell_ch.ready) begin
            if (cells_due.size() == 0) begin
                errors++;
                $display("%0t ns: expected no word, got tag %0d index %0d last %0d trunc %0d",
                         $time, cell_ch.result_tag, cell_ch.cell_index, cell_ch.last_cell,
                         cell_ch.run_truncated);
            end else begin
                cell_want = cells_due.pop_front();
                check_field("result_tag", cell_want.result_tag, cell_ch.result_tag);
                check_field("cell_index", cell_want.cell_index, cell_ch.cell_index);
                check_field("last_cell", cell_want.last_cell, cell_ch.last_cell);
                check_field("run_truncated", cell_want.run_truncated, cell_ch.run_truncated);
            end
        end
    end

    // output pacing: a fresh stall per word, or a long hold when one is requested
    initial begin : cell_pacing
        int stall;
        cell_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = pick_gap();
            if (hold_off_req > 0) begin
                stall = hold_off_req;
                hold_off_req = 0;
            end
            if (stall > 0) begin
                @(negedge i_clk) cell_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) cell_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!cell_ch.valid) @(posedge i_clk);
        end
    end

    task automatic send_box(input t_box b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) box_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        box_ch.valid     <= 1'b1;
        box_ch.box_min_x <= b.box_min[0];
        box_ch.box_min_y <= b.box_min[1];
        box_ch.box_min_z <= b.box_min[2];
        box_ch.box_max_x <= b.box_max[0];
        box_ch.box_max_y <= b.box_max[1];
        box_ch.box_max_z <= b.box_max[2];
        box_ch.box_tag   <= b.box_tag;
        @(posedge i_clk);
        while (!box_ch.ready) @(posedge i_clk);
        bin_box(b);
    endtask

    task automatic await_results();
        @(negedge i_clk) box_ch.valid <= 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
    endtask

    // an empty box leaves no word behind, so give it time to finish
    task automatic settle();
        await_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: grid_origin[idx] = value;
            REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: cell_size[idx - REG_SIZE_X] = value[SIZE_W-1:0];
            REG_COUNTS: grid_counts = value[COUNTS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] ox, oy, oz, sx, sy, sz, counts);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        write_reg(REG_COUNTS, counts);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pack_counts(input int cx, cy, cz);
        return CFG_DATA_W'({CNT_W'(cz), CNT_W'(cy), CNT_W'(cx)});
    endfunction

    function automatic t_box box_of(input longint mnx, mny, mnz, mxx, mxy, mxz,
                                    input int tag);
        t_box b;
        b.box_min[0] = COORD_W'(mnx);
        b.box_min[1] = COORD_W'(mny);
        b.box_min[2] = COORD_W'(mnz);
        b.box_max[0] = COORD_W'(mxx);
        b.box_max[1] = COORD_W'(mxy);
        b.box_max[2] = COORD_W'(mxz);
        b.box_tag    = TAG_W'(tag);
        return b;
    endfunction

    function automatic logic [COORD_W-1:0] coord_in_cell(input int axis, input longint cell_pos);
        longint step, v;
        step = step_of(axis);
        v = longint'(grid_origin[axis]) + cell_pos * step
            + longint'($urandom_range(0, 32'(step - 1)));
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return COORD_W'(v);
    endfunction

    // mostly boxes placed on the grid, some turned inside out, some pure noise
    function automatic t_box random_box();
        t_box   b;
        longint first, last;
        int     kind, a;
        kind      = $urandom_range(0, 19);
        b.box_tag = TAG_W'($urandom);
        if (kind < 3) begin
            for (int ax = 0; ax < AXES; ax++) begin
                b.box_min[ax] = $urandom;
                b.box_max[ax] = $urandom;
            end
            return b;
        end
        for (int ax = 0; ax < AXES; ax++) begin
            first = longint'($urandom_range(0, 32'(axis_cells(ax) + 3))) - 2;
            if ($urandom_range(0, 7) == 0)
                last = first + longint'($urandom_range(0, 32'(axis_cells(ax))));
            else
                last = first + longint'($urandom_range(0, 2));
            b.box_min[ax] = coord_in_cell(ax, first);
            b.box_max[ax] = coord_in_cell(ax, last);
        end
        if (kind < 5) begin
            a = $urandom_range(0, AXES - 1);
            {b.box_min[a], b.box_max[a]} = {b.box_max[a], b.box_min[a]};
        end
        return b;
    endfunction

    task automatic random_grid();
        logic [CFG_DATA_W-1:0] org [AXES];
        logic [CFG_DATA_W-1:0] step [AXES];
        int                    cnt [AXES];
        for (int a = 0; a < AXES; a++) begin
            if ($urandom_range(0, 3) == 0)
                org[a] = $urandom;
            else
                org[a] = int'($urandom_range(0, 2000000)) - 1000000;
            case ($urandom_range(0, 9))
                0: step[a] = '0;
                1: step[a] = $urandom;
                2, 3: step[a] = $urandom_range(1, 1 << 24);
                default: step[a] = $urandom_range(1, 4096);
            endcase
            case ($urandom_range(0, 31))
                0: cnt[a] = 0;
                1, 2: cnt[a] = $urandom_range(65, 127);
                default: cnt[a] = $urandom_range(1, 64);
            endcase
        end
        set_grid(org[0], org[1], org[2], step[0], step[1], step[2],
                 pack_counts(cnt[0], cnt[1], cnt[2]));
    endtask

    // grid as it comes out of reset: 10 x 10 x 1
    task automatic test_reset_grid();
        send_box(box_of(0, 0, 0, 0, 0, 0, 16'h0000));
        send_box(box_of(XY0, XY0, 0, -XY0 - 1, -XY0 - 1, 0, 16'hFFFF));
        send_box(box_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                        16'hA5A5));
        send_box(box_of(XY0, XY0, 0, XY0 + 7 * XY_STEP, XY0 + 7 * XY_STEP, 0, 16'h0040));
        send_box(box_of(XY0, XY0, 0, XY0 + 6 * XY_STEP, XY0 + 8 * XY_STEP, 0, 16'h003F));
        send_box(box_of(XY0, XY0, 0, XY0 + 6 * XY_STEP, -XY0 - 1, 0, 16'h0046));
        send_box(box_of(1000, 0, 0, -1000, 0, 0, 16'h1111));
        send_box(box_of(-XY0, 0, 0, 2000000, 0, 0, 16'h2222));
        send_box(box_of(XY0 - XY_STEP + 1, XY0 - 1, -129, XY0 - 1, XY0 - 1, -129, 16'h3333));
        send_box(box_of(XY0 - XY_STEP, 0, 0, XY0 - XY_STEP, 0, 0, 16'h4444));
        send_box(box_of(-XY0 - 1, -XY0 - 1, 127, -XY0, -XY0, 128, 16'h5555));
        settle();
    endtask

    task automatic test_registers();
        set_grid('0, '0, '0, 32'd1, 32'd1, 32'd1, pack_counts(64, 64, 64));
        send_box(box_of(0, 0, 63, 63, 0, 63, 16'h0001));
        send_box(box_of(63, 63, 63, 63, 63, 63, 16'h0002));
        send_box(box_of(0, 0, 0, 100, 100, 100, 16'h0003));
        settle();
        // zero size, sizes with the top bit set, oversized and empty counts
        set_grid('0, 32'h8000_0000, 32'h7FFF_FFFF, '0, 32'hFFFF_FFFF, 32'h8000_0001,
                 pack_counts(127, 0, 1));
        send_box(box_of(60, COORD_MIN, COORD_MAX, 70, COORD_MAX, COORD_MAX, 16'h0004));
        settle();
        write_reg(REG_COUNTS, pack_counts(127, 2, 1));
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        send_box(box_of(60, COORD_MIN, COORD_MAX, 70, COORD_MAX, COORD_MAX, 16'h0005));
        send_box(box_of(COORD_MIN, 0, 0, COORD_MIN, 0, 0, 16'h0006));
        settle();
        write_reg(REG_ORIGIN_X, 32'h7FFF_FFFF);
        send_box(box_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        16'h0007));
        settle();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_grid();
            repeat (BOXES_PER_PHASE) begin
                send_box(random_box());
                if ($urandom_range(0, 39) == 0) await_results();
            end
            settle();
        end
    endtask

    // hold the output long enough for the block to back up onto its input
    task automatic test_backpressure();
        set_grid('0, '0, '0, 32'd16, 32'd16, 32'd16, pack_counts(8, 8, 4));
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (16) send_box(random_box());
        settle();
    endtask

    task automatic test_pause();
        repeat (12) begin
            send_box(random_box());
            await_results();
        end
        settle();
    endtask

    task automatic test_steady();
        random_grid();
        steady = 1'b1;
        repeat (40) send_box(random_box());
        settle();
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        box_ch.valid     = 1'b0;
        box_ch.box_min_x = '0;
        box_ch.box_min_y = '0;
        box_ch.box_min_z = '0;
        box_ch.box_max_x = '0;
        box_ch.box_max_y = '0;
        box_ch.box_max_z = '0;
        box_ch.box_tag   = '0;
        grid_origin[0]   = ORIGIN_XY_RST;
        grid_origin[1]   = ORIGIN_XY_RST;
        grid_origin[2]   = ORIGIN_Z_RST;
        cell_size[0]     = SIZE_XY_RST;
        cell_size[1]     = SIZE_XY_RST;
        cell_size[2]     = SIZE_Z_RST;
        grid_counts      = COUNTS_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_grid();
        test_registers();
        test_random();
        test_backpressure();
        test_pause();
        test_steady();
        settle();

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
